/* rtl/core/mbt_pkg.sv */
`timescale 1ns / 1ps

package mbt_pkg;

    // byte classes, in the order the front end checks them
    typedef enum logic [2:0] {
        CLS_SYM,
        CLS_NUM,
        CLS_SPACE,
        CLS_NL,
        CLS_ESC,
        CLS_TEXT
    } t_cls;

    // what the back end is holding between bytes
    typedef enum logic [2:0] {
        PC_NONE,
        PC_SYM,
        PC_SPACE,
        PC_NUM,
        PC_CR,
        PC_TEXT,
        PC_ESC
    } t_pend;

    localparam logic [2:0] KIND_END   = 3'd0;
    localparam logic [2:0] KIND_SYM   = 3'd1;
    localparam logic [2:0] KIND_SPACE = 3'd2;
    localparam logic [2:0] KIND_NUM   = 3'd3;
    localparam logic [2:0] KIND_NL    = 3'd4;
    localparam logic [2:0] KIND_TEXT  = 3'd5;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
        t_cls       cls;
        logic       is_sym;
        logic       is_digit;
    } t_item;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  char_code;
        logic [15:0] run_length;
        logic [30:0] number_value;
        logic        has_point;
        logic        first_of_token;
        logic        last_result;
    } t_result;

    function automatic t_result mk_res(input logic [2:0] kind, input logic [7:0] ch,
                                       input logic [15:0] run, input logic [30:0] num,
                                       input logic pt, input logic first);
        t_result r;
        r.token_kind     = kind;
        r.char_code      = ch;
        r.run_length     = run;
        r.number_value   = num;
        r.has_point      = pt;
        r.first_of_token = first;
        r.last_result    = 1'b0;
        return r;
    endfunction

endpackage

/* rtl/core/mbt_front.sv */
`timescale 1ns / 1ps

module mbt_front import mbt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_end_of_input,
    output logic        o_item_valid,
    output t_item       o_item,
    input  logic        i_item_pop
);

    logic [63:0] r_sym_set [4];
    t_item       r_q [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        w_push;
    logic        w_pop;
    t_item       w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_sym_set[i] <= '0;
        end else if (i_cfg_we) begin
            r_sym_set[i_cfg_index] <= i_cfg_data;
        end
    end

    // classify at the door so later config writes cannot reach queued bytes
    always_comb begin
        w_item.byte_value   = i_byte_value;
        w_item.end_of_input = i_end_of_input;
        w_item.is_sym       = r_sym_set[i_byte_value[7:6]][i_byte_value[5:0]];
        w_item.is_digit     = (i_byte_value >= CH_ZERO) && (i_byte_value <= CH_NINE);
        if (w_item.is_sym) begin
            w_item.cls = CLS_SYM;
        end else if (w_item.is_digit) begin
            w_item.cls = CLS_NUM;
        end else if (i_byte_value == CH_SPACE || i_byte_value == CH_TAB) begin
            w_item.cls = CLS_SPACE;
        end else if (i_byte_value == CH_CR || i_byte_value == CH_LF) begin
            w_item.cls = CLS_NL;
        end else if (i_byte_value == CH_BSLASH) begin
            w_item.cls = CLS_ESC;
        end else begin
            w_item.cls = CLS_TEXT;
        end
    end

    assign o_in_stall   = (r_cnt == 2'd2);
    assign w_push       = i_in_valid && !o_in_stall;
    assign w_pop        = i_item_pop && (r_cnt != 2'd0);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wr <= ~r_wr;
            if (w_pop) r_rd <= ~r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_item;
    end

endmodule

/* rtl/core/mbt_back.sv */
`timescale 1ns / 1ps

module mbt_back import mbt_pkg::*; #(
    parameter int RUN_COUNT_BITS = 16,
    parameter int NUMBER_BITS    = 31
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_pop,
    input  logic    i_room,
    output logic    o_push0,
    output logic    o_push1,
    output t_result o_res0,
    output t_result o_res1
);

    t_pend                     r_pend, n_pend;
    logic [7:0]                r_char, n_char;
    logic [RUN_COUNT_BITS-1:0] r_run, n_run;
    logic [NUMBER_BITS-1:0]    r_acc, n_acc;

    // start of a new token from the current byte
    t_pend                     st_pend;
    logic [7:0]                st_char;
    logic [RUN_COUNT_BITS-1:0] st_run;
    logic [NUMBER_BITS-1:0]    st_acc;
    logic                      st_emit;
    t_result                   st_res;

    logic                      w_fire;
    logic [7:0]                w_b;
    logic [32:0]               w_run_ext;
    logic [15:0]               w_run_out;
    logic [30:0]               w_num_out;
    logic [NUMBER_BITS+3:0]    w_mul;
    logic [NUMBER_BITS-1:0]    w_acc_next;
    t_result                   w_res_run;
    t_result                   w_r0, w_r1;
    logic [1:0]                w_n;
    logic                      w_esc_lit;

    assign w_b       = i_item.byte_value;
    assign w_fire    = i_item_valid && i_room;
    assign w_run_ext = 33'(r_run);
    assign w_run_out = (w_run_ext > 33'd65535) ? 16'hFFFF : w_run_ext[15:0];
    assign w_num_out = 31'(r_acc);
    assign w_res_run = mk_res((r_pend == PC_SYM) ? KIND_SYM : KIND_SPACE, r_char,
                              w_run_out, 31'd0, 1'b0, 1'b0);
    assign w_esc_lit = i_item.is_sym || (w_b == CH_DOT) || (w_b == CH_BSLASH);

    // acc * 10 + digit, clamped to the top value
    assign w_mul = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                   + (NUMBER_BITS+4)'(w_b[3:0]);
    assign w_acc_next = (w_mul[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) ? '1
                                                                   : w_mul[NUMBER_BITS-1:0];

    always_comb begin
        st_pend = PC_NONE;
        st_char = r_char;
        st_run  = r_run;
        st_acc  = r_acc;
        st_emit = 1'b0;
        st_res  = mk_res(KIND_TEXT, w_b, 16'd0, 31'd0, 1'b0, 1'b1);
        case (i_item.cls)
            CLS_SYM: begin
                st_pend = PC_SYM;
                st_char = w_b;
                st_run  = RUN_COUNT_BITS'(1);
            end
            CLS_SPACE: begin
                st_pend = PC_SPACE;
                st_char = w_b;
                st_run  = RUN_COUNT_BITS'(1);
            end
            CLS_NUM: begin
                st_pend = PC_NUM;
                st_acc  = NUMBER_BITS'(w_b[3:0]);
            end
            CLS_NL: begin
                if (w_b == CH_CR) begin
                    st_pend = PC_CR;
                end else begin
                    st_emit = 1'b1;
                    st_res  = mk_res(KIND_NL, CH_LF, 16'd0, 31'd0, 1'b0, 1'b0);
                end
            end
            CLS_ESC: begin
                st_pend = PC_ESC;
            end
            default: begin
                st_pend = PC_TEXT;
                st_emit = 1'b1;
            end
        endcase
    end

    // results of this byte
    always_comb begin
        w_r0 = '0;
        w_r1 = '0;
        w_n  = 2'd0;
        if (i_item.end_of_input) begin
            w_r1 = mk_res(KIND_END, 8'd0, 16'd0, 31'd0, 1'b0, 1'b0);
            w_n  = 2'd2;
            case (r_pend)
                PC_SYM, PC_SPACE: w_r0 = w_res_run;
                PC_NUM:  w_r0 = mk_res(KIND_NUM, 8'd0, 16'd0, w_num_out, 1'b0, 1'b0);
                PC_CR:   w_r0 = mk_res(KIND_NL, CH_LF, 16'd0, 31'd0, 1'b0, 1'b0);
                PC_ESC:  w_r0 = mk_res(KIND_TEXT, CH_BSLASH, 16'd0, 31'd0, 1'b0, 1'b1);
                default: begin
                    w_r0 = w_r1;
                    w_n  = 2'd1;
                end
            endcase
        end else begin
            case (r_pend)
                PC_SYM, PC_SPACE: begin
                    if (w_b != r_char) begin
                        w_r0 = w_res_run;
                        w_r1 = st_res;
                        w_n  = 2'd1 + {1'b0, st_emit};
                    end
                end
                PC_NUM: begin
                    if (i_item.is_digit) begin
                        w_n = 2'd0;
                    end else if (w_b == CH_DOT) begin
                        w_r0 = mk_res(KIND_NUM, 8'd0, 16'd0, w_num_out, 1'b1, 1'b0);
                        w_n  = 2'd1;
                    end else begin
                        w_r0 = mk_res(KIND_NUM, 8'd0, 16'd0, w_num_out, 1'b0, 1'b0);
                        w_r1 = st_res;
                        w_n  = 2'd1 + {1'b0, st_emit};
                    end
                end
                PC_CR: begin
                    w_r0 = mk_res(KIND_NL, CH_LF, 16'd0, 31'd0, 1'b0, 1'b0);
                    w_r1 = st_res;
                    w_n  = (w_b == CH_LF) ? 2'd1 : (2'd1 + {1'b0, st_emit});
                end
                PC_TEXT: begin
                    if (i_item.cls == CLS_TEXT) begin
                        w_r0 = mk_res(KIND_TEXT, w_b, 16'd0, 31'd0, 1'b0, 1'b0);
                        w_n  = 2'd1;
                    end else begin
                        w_r0 = st_res;
                        w_n  = {1'b0, st_emit};
                    end
                end
                PC_ESC: begin
                    if (w_esc_lit) begin
                        w_r0 = mk_res(KIND_TEXT, w_b, 16'd0, 31'd0, 1'b0, 1'b1);
                        w_n  = 2'd1;
                    end else if (w_b == CH_N) begin
                        w_r0 = mk_res(KIND_TEXT, CH_LF, 16'd0, 31'd0, 1'b0, 1'b1);
                        w_n  = 2'd1;
                    end else begin
                        // lone backslash becomes text, then the byte goes on normally
                        w_r0 = mk_res(KIND_TEXT, CH_BSLASH, 16'd0, 31'd0, 1'b0, 1'b1);
                        if (i_item.cls == CLS_TEXT) begin
                            w_r1 = mk_res(KIND_TEXT, w_b, 16'd0, 31'd0, 1'b0, 1'b0);
                            w_n  = 2'd2;
                        end else begin
                            w_r1 = st_res;
                            w_n  = 2'd1 + {1'b0, st_emit};
                        end
                    end
                end
                default: begin
                    w_r0 = st_res;
                    w_n  = {1'b0, st_emit};
                end
            endcase
        end
        if (w_n == 2'd1) w_r0.last_result = 1'b1;
        if (w_n == 2'd2) w_r1.last_result = 1'b1;
    end

    // pending token after this byte
    always_comb begin
        n_pend = r_pend;
        n_char = r_char;
        n_run  = r_run;
        n_acc  = r_acc;
        if (i_item.end_of_input) begin
            n_pend = PC_NONE;
            n_char = 8'd0;
            n_run  = '0;
            n_acc  = '0;
        end else begin
            case (r_pend)
                PC_SYM, PC_SPACE: begin
                    if (w_b == r_char) begin
                        if (r_run != '1) n_run = r_run + RUN_COUNT_BITS'(1);
                    end else begin
                        n_pend = st_pend;
                        n_char = st_char;
                        n_run  = st_run;
                        n_acc  = st_acc;
                    end
                end
                PC_NUM: begin
                    if (i_item.is_digit) begin
                        n_acc = w_acc_next;
                    end else if (w_b == CH_DOT) begin
                        n_pend = PC_NONE;
                    end else begin
                        n_pend = st_pend;
                        n_char = st_char;
                        n_run  = st_run;
                        n_acc  = st_acc;
                    end
                end
                PC_CR: begin
                    if (w_b == CH_LF) begin
                        n_pend = PC_NONE;
                    end else begin
                        n_pend = st_pend;
                        n_char = st_char;
                        n_run  = st_run;
                        n_acc  = st_acc;
                    end
                end
                PC_TEXT: begin
                    if (i_item.cls != CLS_TEXT) begin
                        n_pend = st_pend;
                        n_char = st_char;
                        n_run  = st_run;
                        n_acc  = st_acc;
                    end
                end
                PC_ESC: begin
                    if (w_esc_lit || w_b == CH_N || i_item.cls == CLS_TEXT) begin
                        n_pend = PC_TEXT;
                    end else begin
                        n_pend = st_pend;
                        n_char = st_char;
                        n_run  = st_run;
                        n_acc  = st_acc;
                    end
                end
                default: begin
                    n_pend = st_pend;
                    n_char = st_char;
                    n_run  = st_run;
                    n_acc  = st_acc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= PC_NONE;
            r_char <= 8'd0;
            r_run  <= '0;
            r_acc  <= '0;
        end else if (w_fire) begin
            r_pend <= n_pend;
            r_char <= n_char;
            r_run  <= n_run;
            r_acc  <= n_acc;
        end
    end

    assign o_item_pop = w_fire;
    assign o_push0    = w_fire && (w_n != 2'd0);
    assign o_push1    = w_fire && (w_n == 2'd2);
    assign o_res0     = w_r0;
    assign o_res1     = w_r1;

endmodule

/* rtl/core/mbt_out_fifo.sv */
`timescale 1ns / 1ps

module mbt_out_fifo import mbt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push0,
    input  logic        i_push1,
    input  t_result     i_res0,
    input  t_result     i_res1,
    output logic        o_room,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_token_kind,
    output logic [7:0]  o_char_code,
    output logic [15:0] o_run_length,
    output logic [30:0] o_number_value,
    output logic        o_has_point,
    output logic        o_first_of_token,
    output logic        o_last_result
);

    t_result    r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic [2:0] w_push_n;
    logic       w_pop;
    t_result    w_head;

    assign w_push_n = {2'b00, i_push0} + {2'b00, i_push1};
    assign w_pop    = o_out_valid && !i_out_stall;
    // both result slots must be free before the back end takes an item
    assign o_room   = (r_cnt <= 3'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= r_wr + w_push_n[1:0];
            r_cnt <= r_cnt + w_push_n - {2'b00, w_pop};
            if (w_pop) r_rd <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) r_mem[r_wr] <= i_res0;
        if (i_push1) r_mem[r_wr + 2'd1] <= i_res1;
    end

    assign w_head           = r_mem[r_rd];
    assign o_out_valid      = (r_cnt != 3'd0);
    assign o_token_kind     = w_head.token_kind;
    assign o_char_code      = w_head.char_code;
    assign o_run_length     = w_head.run_length;
    assign o_number_value   = w_head.number_value;
    assign o_has_point      = w_head.has_point;
    assign o_first_of_token = w_head.first_of_token;
    assign o_last_result    = w_head.last_result;

endmodule

/* rtl/core/markup_byte_tokenizer_core.sv */
`timescale 1ns / 1ps
// Byte-stream markup tokenizer.
// Input channel: i_in_valid / o_in_stall carry one request per cycle: a byte, or an
// end marker (i_end_of_input) that flushes the pending token and emits an end token.
// Output channel: o_out_valid / i_out_stall carry tokens; o_last_result marks the
// final token caused by one request. A request yields zero, one or two tokens.
// Configuration: i_cfg_we writes the 64-bit symbol bitmap selected by i_cfg_index;
// write only while no request is in flight.
// Throughput: one request per cycle while the receiver does not stall, limited to one
// token per cycle on the output, so a request that yields two tokens takes two output transfers.
// A token passes through the input queue, then the output queue; the tokenizer state
// update sits between them.
// Reset (i_rst_n, synchronous): clears the bitmaps, pending token and both queues.
// When the receiver stalls, the four-entry output queue fills, the tokenizer halts,
// the two-entry input queue fills and o_in_stall rises; nothing is dropped.
module markup_byte_tokenizer_core import mbt_pkg::*; #(
    parameter int RUN_COUNT_BITS = 16,
    parameter int NUMBER_BITS    = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_token_kind,
    output logic [7:0]  o_char_code,
    output logic [15:0] o_run_length,
    output logic [30:0] o_number_value,
    output logic        o_has_point,
    output logic        o_first_of_token,
    output logic        o_last_result
);

    logic    w_item_valid;
    t_item   w_item;
    logic    w_item_pop;
    logic    w_room;
    logic    w_push0, w_push1;
    t_result w_res0, w_res1;

    mbt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_byte_value  (i_byte_value),
        .i_end_of_input(i_end_of_input),
        .o_item_valid  (w_item_valid),
        .o_item        (w_item),
        .i_item_pop    (w_item_pop)
    );

    mbt_back #(
        .RUN_COUNT_BITS(RUN_COUNT_BITS),
        .NUMBER_BITS   (NUMBER_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(w_item_valid),
        .i_item      (w_item),
        .o_item_pop  (w_item_pop),
        .i_room      (w_room),
        .o_push0     (w_push0),
        .o_push1     (w_push1),
        .o_res0      (w_res0),
        .o_res1      (w_res1)
    );

    mbt_out_fifo u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push0         (w_push0),
        .i_push1         (w_push1),
        .i_res0          (w_res0),
        .i_res1          (w_res1),
        .o_room          (w_room),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_token_kind    (o_token_kind),
        .o_char_code     (o_char_code),
        .o_run_length    (o_run_length),
        .o_number_value  (o_number_value),
        .o_has_point     (o_has_point),
        .o_first_of_token(o_first_of_token),
        .o_last_result   (o_last_result)
    );

endmodule

/* tb/markup_byte_tokenizer_core_tb.sv */
`timescale 1ns / 1ps

module markup_byte_tokenizer_core_tb;
    import mbt_pkg::*;

    localparam logic [1:0] REG_SYMBOL_SET_0 = 2'd0;
    localparam logic [1:0] REG_SYMBOL_SET_1 = 2'd1;
    localparam logic [1:0] REG_SYMBOL_SET_2 = 2'd2;
    localparam logic [1:0] REG_SYMBOL_SET_3 = 2'd3;

    localparam logic [15:0] RUN_LIMIT    = 16'hFFFF;
    localparam longint      NUMBER_LIMIT = 64'h7FFF_FFFF;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          REPORT_LIMIT  = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_SYMBOL_SET_0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_byte_value = '0;
    logic        i_end_of_input = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_token_kind;
    logic [7:0]  o_char_code;
    logic [15:0] o_run_length;
    logic [30:0] o_number_value;
    logic        o_has_point;
    logic        o_first_of_token;
    logic        o_last_result;

    markup_byte_tokenizer_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_byte_value     (i_byte_value),
        .i_end_of_input   (i_end_of_input),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_token_kind     (o_token_kind),
        .o_char_code      (o_char_code),
        .o_run_length     (o_run_length),
        .o_number_value   (o_number_value),
        .o_has_point      (o_has_point),
        .o_first_of_token (o_first_of_token),
        .o_last_result    (o_last_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // tokenizer mirror
    logic [255:0] sym_map = '0;
    t_pend        pend_kind = PC_NONE;
    logic [7:0]   pend_char = '0;
    logic [15:0]  run_count = '0;
    logic [30:0]  number_acc = '0;
    t_result      token_q[$];

    int mismatch_count = 0;
    int burst_left = 0;
    bit steady_mode = 0;
    bit valid_up = 0;
    int stall_mode = 0;
    int pattern_cnt = 0;

    function automatic t_cls classify_byte(input logic [7:0] b);
        if (sym_map[b]) return CLS_SYM;
        if (b >= CH_ZERO && b <= CH_NINE) return CLS_NUM;
        if (b == CH_SPACE || b == CH_TAB) return CLS_SPACE;
        if (b == CH_CR || b == CH_LF) return CLS_NL;
        if (b == CH_BSLASH) return CLS_ESC;
        return CLS_TEXT;
    endfunction

    function automatic void queue_token(input logic [2:0] kind, input logic [7:0] ch,
                                        input logic [15:0] run, input logic [30:0] num,
                                        input logic pt, input logic first);
        t_result t;
        t.token_kind     = kind;
        t.char_code      = ch;
        t.run_length     = run;
        t.number_value   = num;
        t.has_point      = pt;
        t.first_of_token = first;
        t.last_result    = 1'b0;
        token_q.push_back(t);
    endfunction

    function automatic void flush_run();
        queue_token((pend_kind == PC_SYM) ? KIND_SYM : KIND_SPACE, pend_char, run_count,
                    '0, 1'b0, 1'b0);
    endfunction

    function automatic void open_token(input logic [7:0] b);
        t_cls c;
        c = classify_byte(b);
        pend_kind = PC_NONE;
        case (c)
            CLS_SYM, CLS_SPACE: begin
                pend_kind = (c == CLS_SYM) ? PC_SYM : PC_SPACE;
                pend_char = b;
                run_count = 16'd1;
            end
            CLS_NUM: begin
                pend_kind  = PC_NUM;
                number_acc = 31'(b - CH_ZERO);
            end
            CLS_NL: begin
                if (b == CH_CR) pend_kind = PC_CR;
                else queue_token(KIND_NL, CH_LF, '0, '0, 1'b0, 1'b0);
            end
            CLS_ESC: pend_kind = PC_ESC;
            default: begin
                queue_token(KIND_TEXT, b, '0, '0, 1'b0, 1'b1);
                pend_kind = PC_TEXT;
            end
        endcase
    endfunction

    function automatic void tokenize_request(input logic [7:0] b, input logic eoi);
        int     start_size;
        longint grown;
        start_size = token_q.size();
        if (eoi) begin
            case (pend_kind)
                PC_SYM, PC_SPACE: flush_run();
                PC_NUM: queue_token(KIND_NUM, '0, '0, number_acc, 1'b0, 1'b0);
                PC_CR:  queue_token(KIND_NL, CH_LF, '0, '0, 1'b0, 1'b0);
                PC_ESC: queue_token(KIND_TEXT, CH_BSLASH, '0, '0, 1'b0, 1'b1);
                default: ;
            endcase
            queue_token(KIND_END, '0, '0, '0, 1'b0, 1'b0);
            pend_kind  = PC_NONE;
            pend_char  = '0;
            run_count  = '0;
            number_acc = '0;
        end else begin
            case (pend_kind)
                PC_SYM, PC_SPACE: begin
                    if (b == pend_char) begin
                        if (run_count != RUN_LIMIT) run_count = run_count + 16'd1;
                    end else begin
                        flush_run();
                        open_token(b);
                    end
                end
                PC_NUM: begin
                    // raw digit test here: a digit in the symbol map still extends the number
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        grown = longint'(number_acc) * 10 + longint'(b - CH_ZERO);
                        number_acc = (grown > NUMBER_LIMIT) ? 31'(NUMBER_LIMIT) : 31'(grown);
                    end else if (b == CH_DOT) begin
                        queue_token(KIND_NUM, '0, '0, number_acc, 1'b1, 1'b0);
                        pend_kind = PC_NONE;
                    end else begin
                        queue_token(KIND_NUM, '0, '0, number_acc, 1'b0, 1'b0);
                        open_token(b);
                    end
                end
                PC_CR: begin
                    queue_token(KIND_NL, CH_LF, '0, '0, 1'b0, 1'b0);
                    pend_kind = PC_NONE;
                    if (b != CH_LF) open_token(b);
                end
                PC_TEXT: begin
                    if (classify_byte(b) == CLS_TEXT)
                        queue_token(KIND_TEXT, b, '0, '0, 1'b0, 1'b0);
                    else
                        open_token(b);
                end
                PC_ESC: begin
                    pend_kind = PC_TEXT;
                    if (sym_map[b] || b == CH_DOT || b == CH_BSLASH) begin
                        queue_token(KIND_TEXT, b, '0, '0, 1'b0, 1'b1);
                    end else if (b == CH_N) begin
                        queue_token(KIND_TEXT, CH_LF, '0, '0, 1'b0, 1'b1);
                    end else begin
                        // lone backslash becomes text, then handle the byte normally
                        queue_token(KIND_TEXT, CH_BSLASH, '0, '0, 1'b0, 1'b1);
                        if (classify_byte(b) == CLS_TEXT)
                            queue_token(KIND_TEXT, b, '0, '0, 1'b0, 1'b0);
                        else
                            open_token(b);
                    end
                end
                default: open_token(b);
            endcase
        end
        if (token_q.size() > start_size) token_q[token_q.size() - 1].last_result = 1'b1;
    endfunction

    // sample at the falling edge: the token moves at the next rising edge
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (token_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("extra token: k=%0d c=%02h r=%0d n=%0d p=%0b f=%0b l=%0b",
                             o_token_kind, o_char_code, o_run_length, o_number_value,
                             o_has_point, o_first_of_token, o_last_result);
            end else begin
                want = token_q.pop_front();
                if (o_token_kind !== want.token_kind || o_char_code !== want.char_code ||
                    o_run_length !== want.run_length ||
                    o_number_value !== want.number_value ||
                    o_has_point !== want.has_point ||
                    o_first_of_token !== want.first_of_token ||
                    o_last_result !== want.last_result) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("expected: k=%0d c=%02h r=%0d n=%0d p=%0b f=%0b l=%0b",
                                 want.token_kind, want.char_code, want.run_length,
                                 want.number_value, want.has_point, want.first_of_token,
                                 want.last_result);
                        $display("got:      k=%0d c=%02h r=%0d n=%0d p=%0b f=%0b l=%0b",
                                 o_token_kind, o_char_code, o_run_length, o_number_value,
                                 o_has_point, o_first_of_token, o_last_result);
                    end
                end
            end
        end
    end

    // receiver backpressure: free-flowing, random, or periodic segments
    always @(posedge i_clk) begin
        if (pattern_cnt == 0) begin
            stall_mode  <= $urandom_range(0, 2);
            pattern_cnt <= $urandom_range(20, 120);
        end else begin
            pattern_cnt <= pattern_cnt - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: i_out_stall <= (pattern_cnt[3:0] < 4'd6);
        endcase
    end

    task automatic send_request(input logic [7:0] b, input logic eoi);
        bit taken;
        int gap;
        i_in_valid     <= 1'b1;
        i_byte_value   <= b;
        i_end_of_input <= eoi;
        valid_up = 1;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        tokenize_request(b, eoi);
        if (!steady_mode) begin
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    valid_up = 0;
                    repeat (gap) @(posedge i_clk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_request(s[k], 1'b0);
    endtask

    task automatic send_end();
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // hold off the sender until every token has come out
    task automatic wait_for_tokens();
        if (valid_up) begin
            i_in_valid <= 1'b0;
            valid_up = 0;
        end
        @(posedge i_clk);
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_register(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_symbol_map(input logic [255:0] map);
        sym_map = map;
        put_register(REG_SYMBOL_SET_0, map[63:0]);
        put_register(REG_SYMBOL_SET_1, map[127:64]);
        put_register(REG_SYMBOL_SET_2, map[191:128]);
        put_register(REG_SYMBOL_SET_3, map[255:192]);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_symbol();
        logic [7:0] c;
        for (int k = 0; k < 32; k++) begin
            c = 8'($urandom_range(0, 255));
            if (sym_map[c]) return c;
        end
        return c;
    endfunction

    task automatic test_directed_tokens();
        logic [255:0] map;
        map = '0;
        map[8'h00] = 1'b1;
        map[8'h3F] = 1'b1;
        map[8'h40] = 1'b1;
        map[8'h7F] = 1'b1;
        map[8'h80] = 1'b1;
        map[8'hBF] = 1'b1;
        map[8'hC0] = 1'b1;
        map[8'hFF] = 1'b1;
        map["#"] = 1'b1;
        map["*"] = 1'b1;
        map[CH_DOT] = 1'b1;
        load_symbol_map(map);
        // symbol runs, space then tab, saturating number with a dot, CR/LF forms
        send_text("##* \t9999999999.7a\r\n\rx\n");
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_end();
        wait_for_tokens();
    endtask

    task automatic test_escapes();
        logic [255:0] map;
        map = '0;
        map["#"] = 1'b1;
        load_symbol_map(map);
        send_text("\\n\\#\\.\\\\\\q\\ ");
        send_end();
        wait_for_tokens();
        // with n as a symbol the escape keeps it literal; trailing backslash flushes at end
        map["n"] = 1'b1;
        load_symbol_map(map);
        send_text("\\n\\");
        send_end();
        wait_for_tokens();
    endtask

    task automatic test_long_run();
        steady_mode = 1;
        repeat (40) send_request(CH_SPACE, 1'b0);
        send_text("x");
        send_end();
        steady_mode = 0;
        wait_for_tokens();
    endtask

    task automatic send_fragment();
        int         pick;
        int         len;
        logic [7:0] c;
        pick = $urandom_range(0, 19);
        if (pick <= 2) begin
            c = pick_symbol();
            repeat ($urandom_range(1, 5)) send_request(c, 1'b0);
        end else if (pick <= 5) begin
            c = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
            repeat ($urandom_range(1, 6)) send_request(c, 1'b0);
        end else if (pick <= 8) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
            repeat (len) send_request(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            if ($urandom_range(0, 1)) send_request(CH_DOT, 1'b0);
        end else if (pick <= 10) begin
            case ($urandom_range(0, 2))
                0: send_text("\r\n");
                1: send_request(CH_CR, 1'b0);
                default: send_request(CH_LF, 1'b0);
            endcase
        end else if (pick <= 13) begin
            repeat ($urandom_range(1, 6))
                send_request(8'($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25)),
                             1'b0);
        end else if (pick <= 15) begin
            send_request(CH_BSLASH, 1'b0);
            case ($urandom_range(0, 5))
                0: send_request(pick_symbol(), 1'b0);
                1: send_request(CH_N, 1'b0);
                2: send_request(CH_DOT, 1'b0);
                3: send_request(CH_BSLASH, 1'b0);
                4: send_request(8'($urandom_range(0, 255)), 1'b0);
                default: send_end();
            endcase
        end else if (pick <= 18) begin
            send_request(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_end();
        end
    endtask

    task automatic stream_phase(input logic [255:0] map, input int count, input bit pause_mid);
        int sent_before;
        load_symbol_map(map);
        sent_before = 0;
        while (sent_before < count) begin
            send_fragment();
            sent_before++;
            if (pause_mid && sent_before == count / 2) wait_for_tokens();
        end
        send_end();
        wait_for_tokens();
    endtask

    task automatic test_random_streams();
        logic [255:0] map;
        string        marks;
        marks = "#*-_`>[]!|~=+";
        stream_phase('0, 35, 1'b0);
        stream_phase('1, 25, 1'b0);
        map = '0;
        for (int k = 0; k < marks.len(); k++) map[marks[k]] = 1'($urandom_range(0, 1));
        stream_phase(map, 55, 1'b1);
        for (int k = 0; k < 8; k++) map[k * 32 +: 32] = $urandom;
        stream_phase(map, 35, 1'b0);
        for (int k = 0; k < 8; k++) map[k * 32 +: 32] = $urandom & $urandom & $urandom;
        stream_phase(map, 55, 1'b0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_tokens();
        test_escapes();
        test_long_run();
        test_random_streams();
        wait_for_tokens();
        if (mismatch_count == 0) begin
            $display("markup_byte_tokenizer_core test passed");
        end else begin
            $display("markup_byte_tokenizer_core test failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("markup_byte_tokenizer_core test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/mbt_pkg.sv
rtl/core/mbt_front.sv
rtl/core/mbt_back.sv
rtl/core/mbt_out_fifo.sv
rtl/core/markup_byte_tokenizer_core.sv
tb/markup_byte_tokenizer_core_tb.sv
